// ===== hw/rtl/ptep_pkg.sv =====
// Shared constants for the pyrogenic threshold block.
// Used by the channel interfaces, the divider and the top level.
`default_nettype none
package ptep_pkg;
   localparam int VAL_W = 48;          // Q32.16 value width
   localparam int NUM_W = 104;         // dividend width of the shared divider
   localparam int DEN_W = 56;          // divisor width of the shared divider
   localparam int DIV_CNT_W = $clog2(NUM_W);
   localparam int MUL_STEPS = 48;      // multiplier bits scanned per product
   localparam int MUL_CNT_W = $clog2(MUL_STEPS);
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int EULER_SUBSTEPS_DEF = 11;

   localparam logic [2:0] REG_INIT_THR  = 3'd0;
   localparam logic [2:0] REG_DECAY     = 3'd1;
   localparam logic [2:0] REG_YSTAR_SQ  = 3'd2;
   localparam logic [2:0] REG_ALPHA     = 3'd3;
   localparam logic [2:0] REG_YSTAR_ONE = 3'd4;
   localparam logic [2:0] REG_STEP_DAYS = 3'd5;

   localparam logic [4:0] STEP_DAYS_RESET = 5'd5;
endpackage
`default_nettype wire

// ===== hw/rtl/ptep_req_if.sv =====
// Input channel: one host time step per word.
// Depends on ptep_pkg.
`default_nettype none
interface ptep_req_if import ptep_pkg::*;;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] total_density;
   logic [VAL_W-1:0] max_density;
   logic             new_host;
   modport source (output valid, total_density, max_density, new_host, input ready);
   modport sink (input valid, total_density, max_density, new_host, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ptep_rsp_if.sv =====
// Result channel: episode probability and updated threshold.
// Depends on ptep_pkg.
`default_nettype none
interface ptep_rsp_if import ptep_pkg::*;;
   logic             valid;
   logic             ready;
   logic [15:0]      episode_prob;
   logic [VAL_W-1:0] threshold_out;
   modport source (output valid, episode_prob, threshold_out, input ready);
   modport sink (input valid, episode_prob, threshold_out, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pyrogenic_threshold_episode_prob.sv =====
// Pyrogenic threshold update and clinical episode probability, top level.
// Depends on ptep_pkg, ptep_req_if, ptep_rsp_if and ptep_div.
//
// One input word is one host time step. The block works on one word at a
// time and drops req ready until the step is done. A step takes one shift-add
// product and one division for the growth constant, then per Euler
// substep one division for growth, two shift-add products for decay (the
// decay product, then a multiply by the reciprocal of the substep count) and
// one update state, and one final division for the probability. Every
// division runs on a single shared radix-2 divider; a zero divisor skips its
// division. The result word waits in an output register, and the next input
// word is taken while it waits.
`default_nettype none
module pyrogenic_threshold_episode_prob import ptep_pkg::*; #(
   parameter int EULER_SUBSTEPS = EULER_SUBSTEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ptep_req_if.sink              req_bus,
   ptep_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   localparam int SUB_W = $clog2(EULER_SUBSTEPS + 1);
   localparam logic [VAL_W-1:0] MAX48 = '1;
   // The reciprocal is exact for 48-bit dividends and substep counts up to 64.
   localparam int RECIP_SH = 54;
   localparam logic [63:0] DECAY_RECIP =
      ((64'd1 << RECIP_SH) + 64'(EULER_SUBSTEPS) - 64'd1) / 64'(EULER_SUBSTEPS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_KMUL = 4'd1;
   localparam logic [3:0] S_KDIV = 4'd2;
   localparam logic [3:0] S_GDIV = 4'd3;
   localparam logic [3:0] S_DMUL = 4'd4;
   localparam logic [3:0] S_DREC = 4'd5;
   localparam logic [3:0] S_PDIV = 4'd6;
   localparam logic [3:0] S_OUT  = 4'd7;
   localparam logic [3:0] S_YUPD = 4'd8;

   logic [VAL_W-1:0] init_thr_ff, init_thr_in;
   logic [31:0]      decay_ff, decay_in;
   logic [VAL_W-1:0] ystar_sq_ff, ystar_sq_in;
   logic [VAL_W-1:0] alpha_ff, alpha_in;
   logic [VAL_W-1:0] ystar_one_ff, ystar_one_in;
   logic [4:0]       step_days_ff, step_days_in;

   logic [3:0]           state_ff, state_in;
   logic                 wait_ff, wait_in;
   logic [VAL_W-1:0]     thr_ff, thr_in;
   logic [VAL_W-1:0]     total_ff, total_in;
   logic [VAL_W-1:0]     maxd_ff, maxd_in;
   logic [VAL_W-1:0]     y_ff, y_in;
   logic [NUM_W-1:0]     acc_ff, acc_in;
   logic [NUM_W-1:0]     mcand_ff, mcand_in;
   logic [VAL_W-1:0]     mplier_ff, mplier_in;
   logic [MUL_CNT_W-1:0] mcnt_ff, mcnt_in;
   logic [63:0]          k_ff, k_in;
   logic [VAL_W-1:0]     growth_ff, growth_in;
   logic [SUB_W-1:0]     sub_ff, sub_in;
   logic [15:0]          prob_ff, prob_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_prob_ff, rsp_prob_in;
   logic [VAL_W-1:0]     rsp_thr_ff, rsp_thr_in;

   logic             csr_wr;
   logic [2:0]       csr_idx;
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [DEN_W-1:0] div_den;
   logic [VAL_W:0]   sum_one, sum_sq, sum_max;
   logic [VAL_W-1:0] decay_q;
   logic [VAL_W+1:0] y_next;
   logic             num_zero;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx = csr_paddr[5:3];

   always_comb begin
      case (csr_idx)
         REG_INIT_THR:  csr_prdata = CSR_DATA_W'(init_thr_ff);
         REG_DECAY:     csr_prdata = CSR_DATA_W'(decay_ff);
         REG_YSTAR_SQ:  csr_prdata = CSR_DATA_W'(ystar_sq_ff);
         REG_ALPHA:     csr_prdata = CSR_DATA_W'(alpha_ff);
         REG_YSTAR_ONE: csr_prdata = CSR_DATA_W'(ystar_one_ff);
         REG_STEP_DAYS: csr_prdata = CSR_DATA_W'(step_days_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      sum_one = {1'b0, ystar_one_ff} + {1'b0, total_ff};
      sum_sq = {1'b0, ystar_sq_ff} + {1'b0, y_ff};
      sum_max = {1'b0, y_ff} + {1'b0, maxd_ff};
      case (state_ff)
         S_KDIV: begin
            div_num = acc_ff;
            div_den = DEN_W'(EULER_SUBSTEPS) * DEN_W'(sum_one);
         end
         S_GDIV: begin
            div_num = NUM_W'({k_ff, 16'h0000});
            div_den = DEN_W'(sum_sq);
         end
         S_PDIV: begin
            div_num = NUM_W'({maxd_ff, 16'h0000});
            div_den = DEN_W'(sum_max);
         end
         default: begin
            div_num = acc_ff;
            div_den = '0;
         end
      endcase
      num_zero = (div_num == '0);
      decay_q = acc_ff[RECIP_SH +: VAL_W];
      y_next = {2'b00, y_ff} - {2'b00, decay_q} + {2'b00, growth_ff};
   end

   always_comb begin
      init_thr_in = init_thr_ff;
      decay_in = decay_ff;
      ystar_sq_in = ystar_sq_ff;
      alpha_in = alpha_ff;
      ystar_one_in = ystar_one_ff;
      step_days_in = step_days_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_INIT_THR:  init_thr_in = csr_pwdata[VAL_W-1:0];
            REG_DECAY:     decay_in = csr_pwdata[31:0];
            REG_YSTAR_SQ:  ystar_sq_in = csr_pwdata[VAL_W-1:0];
            REG_ALPHA:     alpha_in = csr_pwdata[VAL_W-1:0];
            REG_YSTAR_ONE: ystar_one_in = csr_pwdata[VAL_W-1:0];
            REG_STEP_DAYS: step_days_in = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      thr_in = thr_ff;
      total_in = total_ff;
      maxd_in = maxd_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      mcnt_in = mcnt_ff;
      k_in = k_ff;
      growth_in = growth_ff;
      sub_in = sub_ff;
      prob_in = prob_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prob_in = rsp_prob_ff;
      rsp_thr_in = rsp_thr_ff;
      div_start = 1'b0;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               total_in = req_bus.total_density;
               maxd_in = req_bus.max_density;
               y_in = req_bus.new_host ? init_thr_ff : thr_ff;
               mcand_in = NUM_W'(53'(alpha_ff) * 53'(step_days_ff));
               mplier_in = req_bus.total_density;
               acc_in = '0;
               mcnt_in = '0;
               sub_in = '0;
               wait_in = 1'b0;
               state_in = S_KMUL;
            end
         end
         S_KMUL, S_DMUL, S_DREC: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = {mcand_ff[NUM_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[VAL_W-1:1]};
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
               case (state_ff)
                  S_KMUL: state_in = S_KDIV;
                  S_DMUL: begin
                     // The decay product scaled by 2^-32 is divided by the
                     // substep count through a multiply by its reciprocal.
                     mcand_in = NUM_W'(DECAY_RECIP);
                     mplier_in = acc_in[32 +: VAL_W];
                     acc_in = '0;
                     mcnt_in = '0;
                     state_in = S_DREC;
                  end
                  default: state_in = S_YUPD;
               endcase
            end
         end
         S_YUPD: begin
            y_in = (|y_next[VAL_W+1:VAL_W]) ? MAX48 : y_next[VAL_W-1:0];
            sub_in = sub_ff + 1'b1;
            if (sub_ff == SUB_W'(EULER_SUBSTEPS - 1)) begin
               thr_in = y_in;
               state_in = S_PDIV;
            end else begin
               state_in = S_GDIV;
            end
         end
         S_KDIV, S_GDIV, S_PDIV: begin
            if (!wait_ff) begin
               if (div_den == '0) begin
                  // A zero divisor saturates a nonzero dividend and passes zero.
                  case (state_ff)
                     S_KDIV: begin
                        k_in = num_zero ? 64'd0 : '1;
                        state_in = S_GDIV;
                     end
                     S_GDIV: begin
                        growth_in = num_zero ? '0 : MAX48;
                        mcand_in = NUM_W'(decay_ff);
                        mplier_in = y_ff;
                        acc_in = '0;
                        mcnt_in = '0;
                        state_in = S_DMUL;
                     end
                     default: begin
                        prob_in = '0;
                        state_in = S_OUT;
                     end
                  endcase
               end else begin
                  div_start = 1'b1;
                  wait_in = 1'b1;
               end
            end else if (div_done) begin
               wait_in = 1'b0;
               case (state_ff)
                  S_KDIV: begin
                     k_in = (|div_quo[NUM_W-1:64]) ? '1 : div_quo[63:0];
                     state_in = S_GDIV;
                  end
                  S_GDIV: begin
                     growth_in = (|div_quo[NUM_W-1:VAL_W]) ? MAX48 : div_quo[VAL_W-1:0];
                     mcand_in = NUM_W'(decay_ff);
                     mplier_in = y_ff;
                     acc_in = '0;
                     mcnt_in = '0;
                     state_in = S_DMUL;
                  end
                  default: begin
                     prob_in = (|div_quo[NUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_prob_in = prob_ff;
               rsp_thr_in = y_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_thr_ff <= '0;
         decay_ff <= '0;
         ystar_sq_ff <= '0;
         alpha_ff <= '0;
         ystar_one_ff <= '0;
         step_days_ff <= STEP_DAYS_RESET;
         state_ff <= S_IDLE;
         wait_ff <= 1'b0;
         thr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_thr_ff <= init_thr_in;
         decay_ff <= decay_in;
         ystar_sq_ff <= ystar_sq_in;
         alpha_ff <= alpha_in;
         ystar_one_ff <= ystar_one_in;
         step_days_ff <= step_days_in;
         state_ff <= state_in;
         wait_ff <= wait_in;
         thr_ff <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff <= total_in;
      maxd_ff <= maxd_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      mcnt_ff <= mcnt_in;
      k_ff <= k_in;
      growth_ff <= growth_in;
      sub_ff <= sub_in;
      prob_ff <= prob_in;
      rsp_prob_ff <= rsp_prob_in;
      rsp_thr_ff <= rsp_thr_in;
   end

   ptep_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.episode_prob = rsp_prob_ff;
   assign rsp_bus.threshold_out = rsp_thr_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/ptep_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ptep_pkg for the operand widths.
`default_nettype none
module ptep_div import ptep_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     nq_ff, nq_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W:0]       rem_sh;
   logic [DEN_W+1:0]     diff;
   logic                 fits;

   always_comb begin
      rem_sh = {rem_ff, nq_ff[NUM_W-1]};
      diff = {1'b0, rem_sh} - {2'b00, den_ff};
      fits = !diff[DEN_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      nq_in = nq_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         nq_in = num;
         den_in = den;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits enter below.
         rem_in = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         nq_in = {nq_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      nq_ff <= nq_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo = nq_ff;
endmodule
`default_nettype wire
